// File: hw/rtl/crlf_line_assembler_defines.svh
// ---------------------------------------------------------------------------
// crlf_line_assembler_defines.svh
// Assertion macros used by the line assembler RTL.
// ---------------------------------------------------------------------------
`ifndef CRLF_LINE_ASSEMBLER_DEFINES_SVH
`define CRLF_LINE_ASSEMBLER_DEFINES_SVH

`ifndef SYNTH
// The antecedent implies the consequent in the same cycle.
`define CLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The antecedent implies the consequent in the next cycle.
`define CLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLA_ASSERT_SAME(label, ante, cons, msg)
`define CLA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/cla_pkg.sv
// ---------------------------------------------------------------------------
// cla_pkg
// Types and character codes shared by the line assembler modules.
// ---------------------------------------------------------------------------
package cla_pkg;

  // Request function codes.
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Line terminator characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Phase of the line under reception.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_COLLECT  = 3'b010,
    PH_AFTER_CR = 3'b100
  } phase_t;

  // Read-out sequencer states.
  typedef enum logic [3:0] {
    ES_IDLE = 4'b0001,
    ES_READ = 4'b0010,
    ES_LOAD = 4'b0100,
    ES_HOLD = 4'b1000
  } emit_state_t;

endpackage

// File: hw/rtl/cla_ram.sv
// ---------------------------------------------------------------------------
// cla_ram
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cla_collect.sv
// ---------------------------------------------------------------------------
// cla_collect
// Line phase, character count and pending flag; writes bytes to the store.
// ---------------------------------------------------------------------------
module cla_collect #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            func,
  input  logic [7:0]                      rx_byte,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            line_done,
  output logic [$clog2(BUFFER_BYTES)-1:0] line_len
);
  import cla_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES);

  phase_t        phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic          pending, pending_next;

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    pending_next = pending;
    wr_en        = 1'b0;
    wr_addr      = count;
    wr_data      = rx_byte;
    line_done    = 1'b0;
    if (take) begin
      if (func == FUNC_RELEASE) begin
        pending_next = 1'b0;
      end else begin
        case (phase)
          PH_IDLE: begin
            // The first byte is stored whatever it is, unless a line waits.
            if (!pending) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              count_next = CW'(1);
              phase_next = PH_COLLECT;
            end
          end
          PH_COLLECT: begin
            if (rx_byte == CH_CR) begin
              phase_next = PH_AFTER_CR;
            end else if (count != CW'(BUFFER_BYTES - 1)) begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
          end
          PH_AFTER_CR: begin
            if (rx_byte == CH_LF) begin
              line_done    = 1'b1;
              count_next   = '0;
              phase_next   = PH_IDLE;
              pending_next = 1'b1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  assign line_len = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      count   <= '0;
      pending <= 1'b0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      pending <= pending_next;
    end
  end

endmodule

// File: hw/rtl/cla_emit.sv
// ---------------------------------------------------------------------------
// cla_emit
// Reads a finished line out of the store into the output register.
// ---------------------------------------------------------------------------
`include "crlf_line_assembler_defines.svh"

module cla_emit #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [$clog2(BUFFER_BYTES)-1:0] line_len,
  output logic                            busy,
  output logic                            rd_en,
  output logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
  input  logic [7:0]                      rd_data,
  output logic                            line_valid,
  input  logic                            line_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);
  import cla_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES);

  emit_state_t   state, state_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] len;

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    case (state)
      ES_IDLE: begin
        if (start) begin
          rd_idx_next = '0;
          state_next  = ES_READ;
        end
      end
      ES_READ: state_next = ES_LOAD;
      ES_LOAD: state_next = ES_HOLD;
      ES_HOLD: begin
        if (line_ready) begin
          if (out_last) begin
            state_next = ES_IDLE;
          end else begin
            rd_idx_next = rd_idx + CW'(1);
            state_next  = ES_READ;
          end
        end
      end
      default: state_next = ES_IDLE;
    endcase
  end

  assign busy       = (state != ES_IDLE);
  assign rd_en      = (state == ES_READ);
  assign rd_addr    = rd_idx;
  assign line_valid = (state == ES_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ES_IDLE;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ES_IDLE && start) begin
      len <= line_len;
    end
    if (state == ES_LOAD) begin
      out_byte <= rd_data;
      out_last <= (rd_idx == len - CW'(1));
    end
  end

  // A finished line must never arrive while the previous one is read out.
  `CLA_ASSERT_SAME(a_start_when_idle, start, state == ES_IDLE, "line done while busy")
  // Every finished line holds at least one character.
  `CLA_ASSERT_SAME(a_len_nonzero, start, line_len != '0, "empty line finished")
  // The read index stays inside the line being read out.
  `CLA_ASSERT_SAME(a_idx_in_line, state == ES_LOAD, rd_idx < len, "read past line end")

endmodule

// File: hw/rtl/crlf_line_assembler.sv
// ---------------------------------------------------------------------------
// crlf_line_assembler
// Assembles received bytes into CR LF terminated lines and reads them out.
// ---------------------------------------------------------------------------
// Usage: each request on the rx channel carries func and rx_byte. With func
// set to byte, rx_byte is a received character; with func set to release,
// the pending line flag is cleared. A kept character is written into the
// line store RAM when its byte is taken. A line opens with any byte while
// no line is pending, collects until a carriage return (at most
// BUFFER_BYTES-1 characters are kept, the rest are dropped), and is closed
// by the next line feed. The line feed starts the read-out: the line leaves
// on the line channel as out_byte, one character per request, with out_last
// set on the final one. Each character passes through a RAM read, a load of
// the output register and a hand-off; the first character is offered once
// the read-out sequencer reaches the hand-off. When the receiver stalls, the
// current character holds in the output register and rx_ready stays low
// until the final character is taken. Reset clears the phase, count and
// pending flag at once; the store needs no clearing.
// ---------------------------------------------------------------------------
module crlf_line_assembler #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output logic       line_valid,
  input  logic       line_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import cla_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES);

  logic          take;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          line_done;
  logic [CW-1:0] line_len;
  logic          emit_busy;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Requests are held off for the whole read-out of a finished line.
  assign rx_ready = !emit_busy;
  assign take     = rx_valid && rx_ready;

  cla_collect #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_collect (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .line_done (line_done),
    .line_len  (line_len)
  );

  // Line store: written while collecting, read only during read-out.
  cla_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cla_emit #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .start      (line_done),
    .line_len   (line_len),
    .busy       (emit_busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
